[sv/smalu_pkg.sv]
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared types and constants for the stack machine execution unit.
// ----------------------------------------------------------------------------
package smalu_pkg;

    localparam int STACK_DEPTH   = 512;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 4;
    localparam int IMM_W         = 8;
    localparam int STATUS_W      = 2;
    localparam int STACK_COUNT_W = 10;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W        = $clog2(STACK_DEPTH);
    localparam int ITER_W        = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_NOP   = 4'd0,
        OP_POP   = 4'd1,
        OP_PUSH  = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MUL   = 4'd5,
        OP_DIV   = 4'd6,
        OP_MOD   = 4'd7,
        OP_LT    = 4'd8,
        OP_GT    = 4'd9,
        OP_AND   = 4'd10,
        OP_OR    = 4'd11,
        OP_EQ    = 4'd12,
        OP_NEQ   = 4'd13,
        OP_NOT   = 4'd14,
        OP_PRINT = 4'd15
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_R,
        S_RD_L,
        S_WAIT,
        S_DONE
    } t_state;

    // request from the sequencer to the shared unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;

endpackage

[sv/smalu_if.sv]
// ----------------------------------------------------------------------------
// smalu_in_if / smalu_out_if
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
interface smalu_in_if;
    logic                          valid;
    logic                          ready;
    logic [smalu_pkg::OP_W-1:0]    op;
    logic [smalu_pkg::IMM_W-1:0]   imm_value;

    modport source (output valid, output op, output imm_value, input ready);
    modport sink   (input valid, input op, input imm_value, output ready);
endinterface

interface smalu_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [smalu_pkg::DATA_W-1:0]          top_value;
    logic                                  printed;
    logic [smalu_pkg::STACK_COUNT_W-1:0]   stack_count;
    logic [smalu_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output top_value, output printed,
                    output stack_count, output status, input ready);
    modport sink   (input valid, input top_value, input printed,
                    input stack_count, input status, output ready);
endinterface

[sv/smalu_ram.sv]
// ----------------------------------------------------------------------------
// smalu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/smalu_alu.sv]
// ----------------------------------------------------------------------------
// smalu_alu
// Shared arithmetic unit: registered add/sub/mul/compare/logic, and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smalu_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  smalu_pkg::t_alu_ctl          i_ctl,
    input  logic [smalu_pkg::DATA_W-1:0] i_left,
    input  logic [smalu_pkg::DATA_W-1:0] i_right,
    output logic                         o_done,
    output logic [smalu_pkg::DATA_W-1:0] o_result
);

    localparam int W = smalu_pkg::DATA_W;
    localparam int IW = smalu_pkg::ITER_W;

    logic              r_busy;
    logic              r_done;
    logic              r_is_mod;
    logic [IW-1:0]     r_iter;
    logic [W-1:0]      r_quot;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_div;
    logic [W-1:0]      r_result;

    logic [W-1:0]      quick;
    logic [W:0]        rem_sh;
    logic [W:0]        diff;
    logic              q_bit;
    logic [W-1:0]      n_rem;
    logic [W-1:0]      n_quot;
    logic              is_div_op;

    always_comb begin
        quick = '0;
        unique case (i_ctl.op)
            smalu_pkg::OP_ADD: quick = i_left + i_right;
            smalu_pkg::OP_SUB: quick = i_left - i_right;
            smalu_pkg::OP_MUL: quick = W'(i_left * i_right);
            smalu_pkg::OP_LT:  quick = W'(i_left < i_right);
            smalu_pkg::OP_GT:  quick = W'(i_left > i_right);
            smalu_pkg::OP_AND: quick = i_left & i_right;
            smalu_pkg::OP_OR:  quick = i_left | i_right;
            smalu_pkg::OP_EQ:  quick = W'(i_left == i_right);
            smalu_pkg::OP_NEQ: quick = W'(i_left != i_right);
            default:           quick = '0;
        endcase
    end

    assign is_div_op = (i_ctl.op == smalu_pkg::OP_DIV) || (i_ctl.op == smalu_pkg::OP_MOD);

    // one restoring step: shift in next dividend bit, try to subtract
    always_comb begin
        rem_sh = {r_rem, r_quot[W-1]};
        diff   = rem_sh - {1'b0, r_div};
        q_bit  = ~diff[W];
        n_rem  = q_bit ? diff[W-1:0] : rem_sh[W-1:0];
        n_quot = {r_quot[W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_iter <= r_iter + IW'(1);
                if (r_iter == IW'(W - 1)) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_result <= r_is_mod ? n_rem : n_quot;
                end
            end else if (i_ctl.start) begin
                if (is_div_op) begin
                    r_busy   <= 1'b1;
                    r_is_mod <= (i_ctl.op == smalu_pkg::OP_MOD);
                    r_iter   <= '0;
                    r_quot   <= i_left;
                    r_rem    <= '0;
                    r_div    <= i_right;
                end else begin
                    r_done   <= 1'b1;
                    r_result <= quick;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[sv/stack_machine_alu.sv]
// ----------------------------------------------------------------------------
// stack_machine_alu
// Executes one stack-machine instruction per input word on a RAM-held stack.
// ----------------------------------------------------------------------------
// flow: nop, push, overflow, underflow go to done; pop, print, not read one
//   operand; binary ops read two; div/mod retire one quotient bit per cycle
// throughput: one instruction in flight; the single stack read port reads
//   one operand at a time, ready returns once the result word is registered
// reset: entry count cleared, stack RAM contents left as they are
module stack_machine_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    smalu_in_if.sink          i_in,
    smalu_out_if.source       o_out
);

    localparam int W  = smalu_pkg::DATA_W;
    localparam int CW = smalu_pkg::CNT_W;
    localparam int AW = smalu_pkg::ADDR_W;

    smalu_pkg::t_state  r_state;
    smalu_pkg::t_state  n_state;
    smalu_pkg::t_op     r_op;
    smalu_pkg::t_op     in_op;
    smalu_pkg::t_status r_status;
    smalu_pkg::t_status acc_status;
    smalu_pkg::t_alu_ctl alu_ctl;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [W-1:0]   r_right;
    logic [W-1:0]   r_val;
    logic           r_out_valid;
    logic [W-1:0]   r_out_top;
    logic           r_out_printed;
    logic [smalu_pkg::STACK_COUNT_W-1:0] r_out_count;
    logic [smalu_pkg::STATUS_W-1:0]      r_out_status;

    logic           accept;
    logic           commit;
    logic           is_unary;
    logic           is_binary;
    logic           is_divmod;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [W-1:0]   ram_rdata;
    logic           alu_done;
    logic [W-1:0]   alu_result;

    assign in_op  = smalu_pkg::t_op'(i_in.op);
    assign accept = i_in.valid && i_in.ready;
    assign commit = (r_state == smalu_pkg::S_DONE) && (!r_out_valid || o_out.ready);

    assign is_unary  = (r_op == smalu_pkg::OP_POP) || (r_op == smalu_pkg::OP_PRINT) ||
                       (r_op == smalu_pkg::OP_NOT);
    assign is_binary = !is_unary && (r_op != smalu_pkg::OP_NOP) && (r_op != smalu_pkg::OP_PUSH);
    assign is_divmod = (r_op == smalu_pkg::OP_DIV) || (r_op == smalu_pkg::OP_MOD);

    // fault check on the incoming word against the current count
    always_comb begin
        acc_status = smalu_pkg::ST_OK;
        unique case (in_op)
            smalu_pkg::OP_NOP: acc_status = smalu_pkg::ST_OK;
            smalu_pkg::OP_PUSH:
                if (r_count >= CW'(smalu_pkg::STACK_DEPTH)) acc_status = smalu_pkg::ST_OVER;
            smalu_pkg::OP_POP, smalu_pkg::OP_PRINT, smalu_pkg::OP_NOT:
                if (r_count == '0) acc_status = smalu_pkg::ST_UNDER;
            default:
                if (r_count < CW'(2)) acc_status = smalu_pkg::ST_UNDER;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smalu_pkg::S_IDLE: begin
                if (accept) begin
                    if (acc_status != smalu_pkg::ST_OK || in_op == smalu_pkg::OP_NOP ||
                        in_op == smalu_pkg::OP_PUSH) begin
                        n_state = smalu_pkg::S_DONE;
                    end else begin
                        n_state = smalu_pkg::S_RD_R;
                    end
                end
            end
            smalu_pkg::S_RD_R: begin
                n_state = is_unary ? smalu_pkg::S_DONE : smalu_pkg::S_RD_L;
            end
            smalu_pkg::S_RD_L: begin
                if (is_divmod && r_right == '0) begin
                    n_state = smalu_pkg::S_DONE;
                end else begin
                    n_state = smalu_pkg::S_WAIT;
                end
            end
            smalu_pkg::S_WAIT: begin
                if (alu_done) n_state = smalu_pkg::S_DONE;
            end
            smalu_pkg::S_DONE: begin
                if (commit) n_state = smalu_pkg::S_IDLE;
            end
            default: n_state = smalu_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready    = (r_state == smalu_pkg::S_IDLE);
        ram_raddr     = AW'(r_count - CW'(1));
        alu_ctl.start = 1'b0;
        alu_ctl.op    = r_op;
        ram_we        = 1'b0;
        ram_waddr     = AW'(r_count - CW'(2));
        n_count       = r_count;
        unique case (r_state)
            smalu_pkg::S_RD_R: ram_raddr = AW'(r_count - CW'(2));
            smalu_pkg::S_RD_L: alu_ctl.start = !(is_divmod && r_right == '0);
            smalu_pkg::S_DONE: begin
                if (r_status == smalu_pkg::ST_OK) begin
                    priority if (r_op == smalu_pkg::OP_PUSH) begin
                        ram_we    = commit;
                        ram_waddr = AW'(r_count);
                        n_count   = r_count + CW'(1);
                    end else if (r_op == smalu_pkg::OP_NOT) begin
                        ram_we    = commit;
                        ram_waddr = AW'(r_count - CW'(1));
                    end else if (is_unary) begin
                        n_count   = r_count - CW'(1);
                    end else if (is_binary) begin
                        ram_we    = commit;
                        n_count   = r_count - CW'(1);
                    end else begin
                        n_count   = r_count;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smalu_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            smalu_pkg::S_IDLE: begin
                if (accept) begin
                    r_op     <= in_op;
                    r_status <= acc_status;
                    r_val    <= (in_op == smalu_pkg::OP_PUSH && acc_status == smalu_pkg::ST_OK)
                                ? W'(i_in.imm_value) : '0;
                end
            end
            smalu_pkg::S_RD_R: begin
                r_right <= ram_rdata;
                r_val   <= (r_op == smalu_pkg::OP_NOT) ? W'(ram_rdata == '0) : ram_rdata;
            end
            smalu_pkg::S_RD_L: begin
                if (is_divmod && r_right == '0) begin
                    r_status <= smalu_pkg::ST_DIVZ;
                    r_val    <= '0;
                end
            end
            smalu_pkg::S_WAIT: begin
                if (alu_done) r_val <= alu_result;
            end
            smalu_pkg::S_DONE: begin
                if (commit) begin
                    r_out_top     <= r_val;
                    r_out_printed <= (r_op == smalu_pkg::OP_PRINT) &&
                                     (r_status == smalu_pkg::ST_OK);
                    r_out_count   <= smalu_pkg::STACK_COUNT_W'(n_count);
                    r_out_status  <= r_status;
                end
            end
            default: ;
        endcase
    end

    smalu_ram #(
        .WIDTH (W),
        .DEPTH (smalu_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // left operand comes straight from the second stack read
    smalu_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_left   (ram_rdata),
        .i_right  (r_right),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.top_value   = r_out_top;
    assign o_out.printed     = r_out_printed;
    assign o_out.stack_count = r_out_count;
    assign o_out.status      = r_out_status;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stack_machine_alu. A predictor class keeps its own
// copy of the operand stack and expects one result word per accepted
// instruction. Stimulus is a directed opening run, random programs with
// random gaps on both channels, and a fill of the whole stack to overflow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smalu_pkg::*;

    localparam int  CLK_HALF_NS  = 5;
    localparam int  RESET_CYCLES = 7;
    localparam int  RANDOM_RUN   = 350;
    localparam int  SETTLE_CYCLES = 60;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    typedef struct packed {
        logic [DATA_W-1:0]        top_value;
        logic                     printed;
        logic [STACK_COUNT_W-1:0] stack_count;
        t_status                  status;
    } t_result_word;

    // tracks the operand stack and the result words still owed by the block
    class stack_predictor;
        logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
        int unsigned       depth;
        t_result_word      pending_words [$];
        int                errors;

        function new();
            depth  = 0;
            errors = 0;
        endfunction

        function void accept_instruction(t_op op, logic [IMM_W-1:0] imm);
            t_result_word      word;
            logic [DATA_W-1:0] lhs;
            logic [DATA_W-1:0] rhs;
            logic [DATA_W-1:0] res;
            word        = '0;
            word.status = ST_OK;
            res         = '0;
            case (op)
                OP_NOP: begin
                end
                OP_PUSH: begin
                    if (depth >= STACK_DEPTH) begin
                        word.status = ST_OVER;
                    end else begin
                        res = DATA_W'(imm);
                        stack_mem[depth] = res;
                        depth++;
                    end
                end
                OP_POP, OP_PRINT, OP_NOT: begin
                    if (depth < 1) begin
                        word.status = ST_UNDER;
                    end else begin
                        lhs = stack_mem[depth-1];
                        if (op == OP_NOT) begin
                            res = (lhs == '0) ? 32'd1 : 32'd0;
                            stack_mem[depth-1] = res;
                        end else begin
                            res = lhs;
                            depth--;
                            word.printed = (op == OP_PRINT);
                        end
                    end
                end
                default: begin
                    if (depth < 2) begin
                        word.status = ST_UNDER;
                    end else begin
                        // top of stack is the right operand
                        rhs = stack_mem[depth-1];
                        lhs = stack_mem[depth-2];
                        case (op)
                            OP_ADD: res = lhs + rhs;
                            OP_SUB: res = lhs - rhs;
                            OP_MUL: res = lhs * rhs;
                            OP_DIV: begin
                                if (rhs == '0) word.status = ST_DIVZ;
                                else res = lhs / rhs;
                            end
                            OP_MOD: begin
                                if (rhs == '0) word.status = ST_DIVZ;
                                else res = lhs % rhs;
                            end
                            OP_LT:  res = (lhs < rhs) ? 32'd1 : 32'd0;
                            OP_GT:  res = (lhs > rhs) ? 32'd1 : 32'd0;
                            OP_AND: res = lhs & rhs;
                            OP_OR:  res = lhs | rhs;
                            OP_EQ:  res = (lhs == rhs) ? 32'd1 : 32'd0;
                            OP_NEQ: res = (lhs != rhs) ? 32'd1 : 32'd0;
                            default: begin
                            end
                        endcase
                        if (word.status == ST_OK) begin
                            stack_mem[depth-2] = res;
                            depth--;
                        end
                    end
                end
            endcase
            if (word.status == ST_OK) word.top_value = res;
            word.stack_count = STACK_COUNT_W'(depth);
            pending_words.push_back(word);
        endfunction

        function void check_word(logic [DATA_W-1:0] top_value, logic printed,
                                 logic [STACK_COUNT_W-1:0] stack_count,
                                 logic [STATUS_W-1:0] status);
            t_result_word exp_word;
            if (pending_words.size() == 0) begin
                $error("unexpected result word: top_value=%0h status=%0d",
                       top_value, status);
                errors++;
                return;
            end
            exp_word = pending_words.pop_front();
            if (top_value !== exp_word.top_value) begin
                $error("top_value: expected %0h, got %0h", exp_word.top_value, top_value);
                errors++;
            end
            if (printed !== exp_word.printed) begin
                $error("printed: expected %0d, got %0d", exp_word.printed, printed);
                errors++;
            end
            if (stack_count !== exp_word.stack_count) begin
                $error("stack_count: expected %0d, got %0d",
                       exp_word.stack_count, stack_count);
                errors++;
            end
            if (status !== exp_word.status) begin
                $error("status: expected %0d, got %0d", exp_word.status, status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   gaps_on;

    stack_predictor stack_model;

    smalu_in_if  instr_ch ();
    smalu_out_if result_ch ();

    stack_machine_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // valid stays high between back-to-back words, it only drops on a gap or a drain
    task automatic issue_instruction(t_op op, logic [IMM_W-1:0] imm);
        if (gaps_on) begin
            while ($urandom_range(99) < 25) begin
                instr_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        instr_ch.valid     <= 1'b1;
        instr_ch.op        <= op;
        instr_ch.imm_value <= imm;
        do @(posedge i_clk); while (!instr_ch.ready);
        stack_model.accept_instruction(op, imm);
    endtask

    task automatic issue_random_instruction();
        int unsigned       pick;
        t_op               op;
        logic [IMM_W-1:0]  imm;
        pick = $urandom_range(99);
        // small bytes make zeros, equal operands and divide by zero common
        imm  = ($urandom_range(99) < 30) ? IMM_W'($urandom_range(0, 3))
                                         : IMM_W'($urandom_range(0, 255));
        if (pick < 5) begin
            op = t_op'($urandom_range(OP_NOP, OP_PRINT));
        end else if (pick < 45 || (stack_model.depth < 2 && pick < 75)) begin
            op = OP_PUSH;
        end else if (pick < 85) begin
            op = t_op'($urandom_range(OP_ADD, OP_NEQ));
        end else if (pick < 90) begin
            op = OP_NOT;
        end else if (pick < 97) begin
            op = ($urandom_range(1) == 0) ? OP_POP : OP_PRINT;
        end else begin
            op = OP_NOP;
        end
        issue_instruction(op, imm);
    endtask

    task automatic wait_results_drained();
        instr_ch.valid <= 1'b0;
        while (stack_model.pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        t_op              ops  [$];
        logic [IMM_W-1:0] imms [$];
        // underflow on an empty stack, then one entry for a binary op
        ops = '{OP_POP, OP_PRINT, OP_NOT, OP_NOP, OP_PUSH, OP_SUB, OP_NOT,
                OP_PUSH, OP_DIV, OP_MOD, OP_OR, OP_PUSH, OP_SUB, OP_PUSH, OP_MUL,
                OP_PUSH, OP_GT, OP_PUSH, OP_LT, OP_PUSH, OP_ADD, OP_PUSH, OP_MOD,
                OP_PUSH, OP_DIV, OP_PUSH, OP_EQ, OP_PUSH, OP_NEQ, OP_PUSH, OP_AND,
                OP_NOT, OP_PRINT};
        imms = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0,
                 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                 8'd85, 8'd0, 8'd7, 8'd0, 8'd2, 8'd0, 8'd2, 8'd0,
                 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0,
                 8'd0, 8'd0};
        foreach (ops[k]) issue_instruction(ops[k], imms[k]);
    endtask

    task automatic run_fill_to_overflow();
        while (stack_model.depth < STACK_DEPTH) begin
            issue_instruction(OP_PUSH, IMM_W'($urandom_range(0, 255)));
        end
        repeat (3) issue_instruction(OP_PUSH, 8'hff);
        issue_instruction(OP_NOT, 8'h00);
        issue_instruction(OP_PRINT, 8'h00);
        issue_instruction(OP_PUSH, 8'h5a);
        issue_instruction(OP_PUSH, 8'ha5);
        // work the stack back down with binary ops and pops
        while (stack_model.depth > 4) begin
            if ($urandom_range(99) < 70)
                issue_instruction(t_op'($urandom_range(OP_ADD, OP_NEQ)), 8'h00);
            else
                issue_instruction(OP_POP, 8'h00);
        end
    endtask

    // result side: random stalls, checks each accepted word
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) begin
                stack_model.check_word(result_ch.top_value, result_ch.printed,
                                       result_ch.stack_count, result_ch.status);
            end
            result_ch.ready <= !gaps_on || ($urandom_range(99) >= 25);
        end
    end

    initial begin
        stack_model        = new();
        gaps_on            = 1'b0;
        i_rst_n            <= 1'b0;
        instr_ch.valid     <= 1'b0;
        instr_ch.op        <= OP_NOP;
        instr_ch.imm_value <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        gaps_on = 1'b1;
        repeat (RANDOM_RUN) issue_random_instruction();
        wait_results_drained();

        gaps_on = 1'b0;
        run_fill_to_overflow();

        gaps_on = 1'b1;
        repeat (RANDOM_RUN) issue_random_instruction();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (stack_model.errors == 0 && stack_model.pending_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
